// ===== rtl/csh_pkg.sv =====
// Shared types and constants for the click series / hold detector.
// No dependencies; imported by every module of the block.
package csh_pkg;

	// event codes of a result transaction
	typedef enum logic [1:0] {
		KIND_SERIES   = 2'd0,
		KIND_HOLD     = 2'd1,
		KIND_HOLD_END = 2'd2
	} kind_t;

	// configuration register indexes
	localparam logic [1:0] REG_HOLD_MIN  = 2'd0;
	localparam logic [1:0] REG_RELEASE   = 2'd1;
	localparam logic [1:0] REG_PRESS_GAP = 2'd2;

	localparam logic [15:0] HOLD_MIN_RST  = 16'd1000;
	localparam logic [15:0] RELEASE_RST   = 16'd250;
	localparam logic [15:0] PRESS_GAP_RST = 16'd50;

	// result queue: two entries per sample plus slack for back-to-back flow
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	typedef struct packed {
		logic [15:0] hold_min_ms;
		logic [15:0] release_ms;
		logic [15:0] press_gap_ms;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  clicks;
		logic [31:0] hold_ms;
		logic        last;
	} result_t;

endpackage

// ===== rtl/click_series_hold_detector_top.sv =====
// Top level of the click series / hold detector: config registers,
// input stage, step logic and result queue. Depends on csh_pkg,
// csh_step and csh_res_fifo.
//
//  channel | signals                              | handshake
//  --------+--------------------------------------+-------------------
//  cfg     | cfg_we, cfg_index, cfg_wdata         | write on cfg_we
//  in      | now_ms, pressed                      | in_valid/in_ready
//  out     | event_kind, clicks, hold_ms, last    | out_valid/out_ready
//
// One sample per cycle is taken unless stalled; it is evaluated once the
// queue has room for all its zero, one or two results, which then enter the
// four-entry queue at once. Results leave at one per cycle while out_ready
// is high. Output stalls back up through the queue into the input stage.
// Reset clears state and the queue; config returns to its defaults.
module click_series_hold_detector_top
	import csh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] now_ms,
	input  logic        pressed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  event_kind,
	output logic [7:0]  clicks,
	output logic [31:0] hold_ms,
	output logic        last
);

	cfg_t               cfg_q;
	logic               valid_s1;
	logic [31:0]        now_s1;
	logic               pressed_s1;

	logic [1:0]         n_res;
	result_t            res0;
	result_t            res1;
	result_t            head;
	logic [FIFO_CW-1:0] count;
	logic [FIFO_CW-1:0] free;
	logic               proc;
	logic               pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_min_ms  <= HOLD_MIN_RST;
			cfg_q.release_ms   <= RELEASE_RST;
			cfg_q.press_gap_ms <= PRESS_GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HOLD_MIN:  cfg_q.hold_min_ms  <= cfg_wdata;
				REG_RELEASE:   cfg_q.release_ms   <= cfg_wdata;
				REG_PRESS_GAP: cfg_q.press_gap_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sample is evaluated only when the queue has room for all its results
	assign free     = FIFO_CW'(FIFO_DEPTH) - count;
	assign proc     = valid_s1 && ({1'b0, n_res} <= free);
	assign in_ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_s1     <= now_ms;
			pressed_s1 <= pressed;
		end
	end

	csh_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (proc),
		.cfg     (cfg_q),
		.now_ms  (now_s1),
		.pressed (pressed_s1),
		.n_res   (n_res),
		.res0    (res0),
		.res1    (res1)
	);

	assign pop = out_valid && out_ready;

	csh_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (proc ? n_res : 2'd0),
		.wr0    (res0),
		.wr1    (res1),
		.pop    (pop),
		.head   (head),
		.count  (count)
	);

	assign out_valid  = (count != '0);
	assign event_kind = head.kind;
	assign clicks     = head.clicks;
	assign hold_ms    = head.hold_ms;
	assign last       = head.last;

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue overfilled");

	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted sample lost before evaluation");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && n_res == 2'd2) |-> (res0.kind != KIND_HOLD && !res0.last && res1.last))
		else $error("series end must precede hold progress");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!proc && !pop) |=> $stable(count))
		else $error("queue level changed without push or pop");

endmodule

// ===== rtl/csh_step.sv =====
// Per-sample evaluation and detector state (click count, hold start,
// last press time, pressed flag). Depends on csh_pkg.
module csh_step
	import csh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  cfg_t        cfg,
	input  logic [31:0] now_ms,
	input  logic        pressed,
	output logic [1:0]  n_res,
	output result_t     res0,
	output result_t     res1
);

	logic [7:0]  click_count_q;
	logic [31:0] hold_start_q;
	logic [31:0] last_press_q;
	logic        pressed_flag_q;

	logic [31:0] since_press;
	logic [31:0] held;
	logic        rel;
	logic        hold_ev;
	logic [7:0]  cnt_nxt;
	logic [31:0] hs_nxt;
	logic        flag_nxt;
	result_t     series_r;
	result_t     hold_r;

	always_comb begin
		since_press = now_ms - last_press_q;
		held        = now_ms - hold_start_q;
		rel         = since_press > {16'd0, cfg.release_ms};

		cnt_nxt  = rel ? 8'd0 : click_count_q;
		hs_nxt   = rel ? now_ms : hold_start_q;
		flag_nxt = rel ? 1'b0 : pressed_flag_q;

		series_r.kind    = (held < {16'd0, cfg.hold_min_ms}) ? KIND_SERIES : KIND_HOLD_END;
		series_r.clicks  = click_count_q;
		series_r.hold_ms = 32'd0;
		series_r.last    = 1'b0;

		if (pressed) begin
			if (since_press > {16'd0, cfg.press_gap_ms}) begin
				cnt_nxt = cnt_nxt + 8'd1;
				hs_nxt  = now_ms;
			end
			flag_nxt = 1'b1;
		end

		// hold test uses the elapsed time taken before this sample's updates
		hold_ev = flag_nxt && (held > {16'd0, cfg.hold_min_ms});

		hold_r.kind    = KIND_HOLD;
		hold_r.clicks  = cnt_nxt;
		hold_r.hold_ms = held;
		hold_r.last    = 1'b1;

		n_res = {1'b0, rel} + {1'b0, hold_ev};
		res0  = rel ? series_r : hold_r;
		res0.last = (n_res == 2'd1);
		res1  = hold_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_count_q  <= 8'd0;
			hold_start_q   <= 32'd0;
			last_press_q   <= 32'd0;
			pressed_flag_q <= 1'b0;
		end else if (en) begin
			click_count_q  <= cnt_nxt;
			hold_start_q   <= hs_nxt;
			pressed_flag_q <= flag_nxt;
			if (pressed)
				last_press_q <= now_ms;
		end
	end

endmodule

// ===== rtl/csh_res_fifo.sv =====
// Result queue: takes zero, one or two results a cycle, gives one per pop.
// Depends on csh_pkg.
module csh_res_fifo
	import csh_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           push_n,
	input  result_t              wr0,
	input  result_t              wr1,
	input  logic                 pop,
	output result_t              head,
	output logic [FIFO_CW-1:0]   count
);

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic [FIFO_AW-1:0]   wr_ptr1;

	assign wr_ptr1 = wr_ptr_q + {{(FIFO_AW-1){1'b0}}, 1'b1};
	assign head    = mem_q[rd_ptr_q];
	assign count   = count_q;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem_q[wr_ptr_q] <= wr0;
		if (push_n == 2'd2)
			mem_q[wr_ptr1] <= wr1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + {{(FIFO_AW-1){1'b0}}, 1'b1};
			count_q <= count_q + FIFO_CW'(push_n) - FIFO_CW'(pop);
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for click_series_hold_detector_top.
// A directed table then phased random button traffic, checked against table
// entries or a local predictor. Depends on csh_pkg and the block's RTL.
module tb_top;
	import csh_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef enum {SEG_HOLD, SEG_CLICKS, SEG_IDLE, SEG_TAPS, SEG_NOISE} seg_kind_t;

	typedef struct {
		logic [31:0] t;
		logic        p;
		bit          fixed_exp;
		int unsigned n_exp;
		kind_t       kind;
		logic [7:0]  clicks;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_HOLD_MIN;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] now_ms = '0;
	logic        pressed = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  event_kind;
	logic [7:0]  clicks;
	logic [31:0] hold_ms;
	logic        last;

	// predictor copy of configuration and state
	logic [15:0] hold_min_cfg, release_cfg, gap_cfg;
	logic [7:0]  click_total;
	logic [31:0] hold_start_ms, last_press_ms;
	logic        hold_flag;

	result_t     pending_events[$];
	stim_row_t   stim_table[16];
	logic [31:0] sample_ms;
	bit          send_calm = 1'b0;
	bit          sink_calm = 1'b0;
	int unsigned err_count = 0;

	click_series_hold_detector_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.now_ms    (now_ms),
		.pressed   (pressed),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.event_kind(event_kind),
		.clicks    (clicks),
		.hold_ms   (hold_ms),
		.last      (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		err_count++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	function automatic void reset_detector_model();
		hold_min_cfg  = HOLD_MIN_RST;
		release_cfg   = RELEASE_RST;
		gap_cfg       = PRESS_GAP_RST;
		click_total   = '0;
		hold_start_ms = '0;
		last_press_ms = '0;
		hold_flag     = 1'b0;
	endfunction

	// one button sample; both tests use the elapsed times from the start of the step
	function automatic void advance_detector(input logic [31:0] t, input logic p,
		input bit enqueue);
		logic [31:0] since_press, held;
		result_t     ev0, ev1, hold_ev;
		int unsigned n;
		since_press = t - last_press_ms;
		held        = t - hold_start_ms;
		n           = 0;
		ev0         = '0;
		ev1         = '0;
		if (since_press > {16'd0, release_cfg}) begin
			ev0.kind    = (held < {16'd0, hold_min_cfg}) ? KIND_SERIES : KIND_HOLD_END;
			ev0.clicks  = click_total;
			ev0.hold_ms = '0;
			ev0.last    = 1'b0;
			n           = 1;
			click_total   = '0;
			hold_flag     = 1'b0;
			hold_start_ms = t;
		end
		if (p) begin
			if (since_press > {16'd0, gap_cfg}) begin
				click_total   = click_total + 8'd1;
				hold_start_ms = t;
			end
			last_press_ms = t;
			hold_flag     = 1'b1;
		end
		if (hold_flag && held > {16'd0, hold_min_cfg}) begin
			hold_ev.kind    = KIND_HOLD;
			hold_ev.clicks  = click_total;
			hold_ev.hold_ms = held;
			hold_ev.last    = 1'b0;
			if (n == 0)
				ev0 = hold_ev;
			else
				ev1 = hold_ev;
			n++;
		end
		if (enqueue) begin
			if (n == 1)
				ev0.last = 1'b1;
			if (n == 2)
				ev1.last = 1'b1;
			if (n >= 1)
				pending_events.push_back(ev0);
			if (n == 2)
				pending_events.push_back(ev1);
		end
	endfunction

	task automatic send_sample(input logic [31:0] t, input logic p, input bit predict);
		int unsigned w;
		w = send_calm ? 0 : $urandom_range(0, 6);
		if (w != 0) begin
			in_valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_ms   <= t;
		pressed  <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		advance_detector(t, p, predict);
	endtask

	// sender holds off until every expected transaction is out, then lets the pipe settle
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic apply_config(input logic [15:0] h, input logic [15:0] r,
		input logic [15:0] g, input bit poke_unused);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= REG_HOLD_MIN;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_index <= REG_RELEASE;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_index <= REG_PRESS_GAP;
		cfg_wdata <= g;
		@(posedge clk);
		if (poke_unused) begin
			cfg_index <= REG_UNUSED;
			cfg_wdata <= 16'($urandom);
			@(posedge clk);
		end
		cfg_we       <= 1'b0;
		hold_min_cfg = h;
		release_cfg  = r;
		gap_cfg      = g;
	endtask

	function automatic logic [15:0] pick_setting(input int unsigned span);
		if ($urandom_range(0, 7) == 0)
			return 16'($urandom);
		return 16'($urandom_range(0, span));
	endfunction

	task automatic run_random(input int unsigned count);
		int unsigned left, seg, r;
		seg_kind_t   kind;
		logic        p;
		left = count;
		while (left > 0) begin
			r = $urandom_range(0, 9);
			if (r < 3)
				kind = SEG_HOLD;
			else if (r < 6)
				kind = SEG_CLICKS;
			else if (r < 8)
				kind = SEG_IDLE;
			else if (r < 9)
				kind = SEG_TAPS;
			else
				kind = SEG_NOISE;
			seg = $urandom_range(4, 40);
			if (seg > left)
				seg = left;
			send_calm = ($urandom_range(0, 4) == 0);
			repeat (seg) begin
				case (kind)
					SEG_HOLD: begin
						// presses closer than the gap keep one hold running
						p = ($urandom_range(0, 9) != 0);
						sample_ms += $urandom_range(0, gap_cfg);
					end
					SEG_CLICKS: begin
						p = 1'($urandom);
						sample_ms += $urandom_range(0, release_cfg + 20);
					end
					SEG_IDLE: begin
						p = 1'b0;
						sample_ms += $urandom_range(0, 2 * release_cfg + 2);
					end
					SEG_TAPS: begin
						p = 1'b1;
						sample_ms += $urandom_range(gap_cfg, gap_cfg + release_cfg + 1);
					end
					default: begin
						p = 1'($urandom);
						sample_ms = $urandom;
					end
				endcase
				send_sample(sample_ms, p, 1'b1);
			end
			left -= seg;
		end
		send_calm = 1'b0;
	endtask

	// result side: random stalls, each transaction checked against the oldest expectation
	initial begin
		result_t     want;
		int unsigned w;
		wait (arst_n === 1'b1);
		forever begin
			w = sink_calm ? 0 : $urandom_range(0, 6);
			if (w != 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (pending_events.size() == 0) begin
				flag_error($sformatf("unexpected result kind=%0d clicks=%0d hold=%0d",
					event_kind, clicks, hold_ms));
			end else begin
				want = pending_events.pop_front();
				if (event_kind !== want.kind)
					flag_error($sformatf("event_kind %0d, want %0d", event_kind, want.kind));
				if (clicks !== want.clicks)
					flag_error($sformatf("clicks %0d, want %0d", clicks, want.clicks));
				if (hold_ms !== want.hold_ms)
					flag_error($sformatf("hold_ms %0d, want %0d", hold_ms, want.hold_ms));
				if (last !== want.last)
					flag_error($sformatf("last %0b, want %0b", last, want.last));
			end
			if ($urandom_range(0, 31) == 0)
				sink_calm = !sink_calm;
		end
	end

	initial begin
		#2000000;
		$display("click_series_hold_detector_top regression: fail");
		$finish;
	end

	initial begin
		stim_table = '{
			'{32'd0,          1'b0, 1'b1, 0, KIND_SERIES, 8'd0},  // nothing after reset
			'{32'd251,        1'b0, 1'b1, 1, KIND_SERIES, 8'd0},  // first silence end
			'{32'd300,        1'b1, 1'b0, 0, KIND_SERIES, 8'd0},
			'{32'd350,        1'b0, 1'b0, 0, KIND_SERIES, 8'd0},
			'{32'd400,        1'b1, 1'b0, 0, KIND_SERIES, 8'd0},
			'{32'd420,        1'b1, 1'b0, 0, KIND_SERIES, 8'd0},
			'{32'd2400,       1'b1, 1'b0, 0, KIND_SERIES, 8'd0},  // hold end then hold
			'{32'd2600,       1'b0, 1'b0, 0, KIND_SERIES, 8'd0},
			'{32'd2851,       1'b0, 1'b0, 0, KIND_SERIES, 8'd0},
			'{32'd2851,       1'b0, 1'b1, 1, KIND_SERIES, 8'd0},  // idle repeat
			'{32'hFFFF_FFFF,  1'b1, 1'b0, 0, KIND_SERIES, 8'd0},
			'{32'h0000_0010,  1'b1, 1'b0, 0, KIND_SERIES, 8'd0},  // time wrap
			'{32'h0000_0030,  1'b1, 1'b0, 0, KIND_SERIES, 8'd0},
			'{32'h0000_0080,  1'b0, 1'b0, 0, KIND_SERIES, 8'd0},
			'{32'h0000_017B,  1'b0, 1'b0, 0, KIND_SERIES, 8'd0},
			'{32'h0000_017B,  1'b1, 1'b0, 0, KIND_SERIES, 8'd0}
		};
		reset_detector_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			send_sample(stim_table[i].t, stim_table[i].p, !stim_table[i].fixed_exp);
			if (stim_table[i].fixed_exp && stim_table[i].n_exp == 1)
				pending_events.push_back('{stim_table[i].kind, stim_table[i].clicks,
					32'd0, 1'b1});
		end

		sample_ms = 32'd2000;
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: ;
				1: apply_config(16'd0, 16'd0, 16'd0, 1'b1);
				2: apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
				3: begin
					// back-to-back clicks past the 8-bit counter wrap
					apply_config(16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
					repeat (300) begin
						sample_ms += 1;
						send_sample(sample_ms, 1'b1, 1'b1);
					end
					sample_ms += 70000;
					send_sample(sample_ms, 1'b0, 1'b1);
				end
				default: apply_config(pick_setting(2500), pick_setting(600),
					pick_setting(150), ph == 5);
			endcase
			if (ph == 4)
				sample_ms = 32'hFFFF_F000;
			if (ph != 3)
				run_random(195);
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("click_series_hold_detector_top regression: pass");
		else
			$display("click_series_hold_detector_top regression: fail");
		$finish;
	end

endmodule
